// ===== hdl/assert_macros.svh =====
// Assertion macros used by the controller of the position stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SVPS_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SVPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SVPS_ASSERT_RST(lbl, clk, rstn, prop)
`define SVPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/svps_pkg.sv =====
// Package with shared constants, codes and control structs of the position stepper.
package svps_pkg;

  localparam int VOICES_DEF    = 32;
  localparam int ADDR_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF = 32;

  localparam logic [5:0] CIN_RESET = 6'd8;

  // Width of the signed working position and of the remainder dividend.
  localparam int SW = 36;
  localparam int DW = 34;

  typedef enum logic [1:0] {
    CMD_TRIGGER  = 2'd0,
    CMD_SET_STEP = 2'd1,
    CMD_ADVANCE  = 2'd2,
    CMD_STOP_ALL = 2'd3
  } svps_op_e;

  localparam logic [1:0] LOOP_NONE = 2'd0;
  localparam logic [1:0] LOOP_FWD  = 2'd1;

  typedef struct packed {
    logic capture;
    logic eval;
    logic classify;
    logic div_step;
    logic commit;
    logic load_out;
  } svps_ctl_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } svps_sts_t;

endpackage

// ===== hdl/sample_voice_position_stepper.sv =====
// Top level of the per-voice sample playback position stepper.
//
// Each input word carries a command (trigger, set step, advance, stop all)
// for one voice, and each accepted word yields exactly one output word that
// reports that voice: active flag, frame position, direction and the byte
// position with its valid flag. Voices at or above channels_in_use report
// all zeros. The channels_in_use register is written through cfg_we_i.
// When an advance overruns a loop of length two or more, the overrun is
// reduced by a restoring remainder unit that resolves one of 34 bits per
// cycle. One word is in work at a time, so a new word is taken only after
// the previous one is finished. The finished word sits in an output
// register, so in_stall_o drops again while out_stall_i holds that word.
// A stalled output word stays unchanged until it is taken. Reset stops all
// voices, clears positions, steps and directions, and sets channels_in_use
// to 8.
module sample_voice_position_stepper
  import svps_pkg::*;
#(
  parameter int VOICES    = VOICES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  voice_i,
  input  logic        sample_present_i,
  input  logic [23:0] sample_length_i,
  input  logic [23:0] loop_begin_i,
  input  logic [23:0] loop_span_i,
  input  logic [1:0]  loop_mode_i,
  input  logic        is_16bit_i,
  input  logic [23:0] start_offset_i,
  input  logic [47:0] step_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        voice_active_o,
  output logic [23:0] frame_position_o,
  output logic        going_backwards_o,
  output logic        byte_position_valid_o,
  output logic [24:0] byte_position_o
);

  svps_ctl_t ctl;
  svps_sts_t sts;

  svps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  svps_dp #(
    .VOICES    (VOICES),
    .ADDR_BITS (ADDR_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ctl_i                 (ctl),
    .sts_o                 (sts),
    .cfg_we_i              (cfg_we_i),
    .cfg_data_i            (cfg_data_i),
    .cmd_i                 (cmd_i),
    .voice_i               (voice_i),
    .sample_present_i      (sample_present_i),
    .sample_length_i       (sample_length_i),
    .loop_begin_i          (loop_begin_i),
    .loop_span_i           (loop_span_i),
    .loop_mode_i           (loop_mode_i),
    .is_16bit_i            (is_16bit_i),
    .start_offset_i        (start_offset_i),
    .step_i                (step_i),
    .voice_active_o        (voice_active_o),
    .frame_position_o      (frame_position_o),
    .going_backwards_o     (going_backwards_o),
    .byte_position_valid_o (byte_position_valid_o),
    .byte_position_o       (byte_position_o)
  );

endmodule

// ===== hdl/svps_ctrl.sv =====
// Controller state machine of the position stepper.
`include "assert_macros.svh"

module svps_ctrl
  import svps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  svps_sts_t sts_i,
  output svps_ctl_t ctl_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_CLASS  = 6'b000100,
    S_DIV    = 6'b001000,
    S_COMMIT = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl_o.eval = 1'b1;
        state_d    = S_CLASS;
      end
      S_CLASS: begin
        ctl_o.classify = 1'b1;
        state_d        = sts_i.need_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SVPS_ASSERT_RST(a_accept_to_eval, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> (state_q == S_EVAL))
  `SVPS_ASSERT_RST(a_div_done_to_commit, clk_i, rst_ni,
    (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_COMMIT))
  `SVPS_ASSERT_RST(a_out_rise_after_result, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))

endmodule

// ===== hdl/svps_dp.sv =====
// Datapath of the position stepper: voice state, position update, remainder unit, output word.
module svps_dp
  import svps_pkg::*;
#(
  parameter int VOICES    = VOICES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  svps_ctl_t   ctl_i,
  output svps_sts_t   sts_o,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  voice_i,
  input  logic        sample_present_i,
  input  logic [23:0] sample_length_i,
  input  logic [23:0] loop_begin_i,
  input  logic [23:0] loop_span_i,
  input  logic [1:0]  loop_mode_i,
  input  logic        is_16bit_i,
  input  logic [23:0] start_offset_i,
  input  logic [47:0] step_i,
  output logic        voice_active_o,
  output logic [23:0] frame_position_o,
  output logic        going_backwards_o,
  output logic        byte_position_valid_o,
  output logic [24:0] byte_position_o
);

  localparam int VIDX = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PW   = ADDR_BITS + 1;
  localparam int FPW  = (PW > 24) ? PW : 24;
  localparam int CW   = $clog2(DW);
  localparam logic signed [SW-1:0] POS_MAX = signed'(SW'((64'd1 << PW) - 64'd1));

  logic [5:0] cin_q;

  logic [1:0]  cmd_q;
  logic [4:0]  voice_q;
  logic        present_q;
  logic [23:0] len_q, lb_q, lspan_q, start_q;
  logic [1:0]  lmode_q;
  logic        w16_q;
  logic [47:0] step_q;

  logic [VOICES-1:0]    active_q;
  logic [VOICES-1:0]    back_q;
  logic [FPW-1:0]       frame_pos_q [VOICES];
  logic [FRAC_BITS-1:0] frac_pos_q  [VOICES];
  logic [47:0]          step_store_q [VOICES];
  logic [24:0]          end_q       [VOICES];
  logic [2:0]           mode_q      [VOICES];
  logic [23:0]          ls_store_q  [VOICES];
  logic [23:0]          ll_store_q  [VOICES];

  logic signed [SW-1:0] pos_q;
  logic [FRAC_BITS-1:0] frac_n_q;
  logic                 wb_q, ovr_q;
  logic [DW-1:0]        div_q;
  logic [23:0]          rem_q;
  logic [CW-1:0]        cnt_q;

  logic [VIDX-1:0] vidx;
  logic            used;
  logic            adv;
  logic signed [SW-1:0] ls_s, ll_s, end_s, pos_cur_s;

  assign vidx = VIDX'(voice_q);
  assign used = ({1'b0, voice_q} < cin_q) && (32'(voice_q) < VOICES);
  assign adv  = (cmd_q == CMD_ADVANCE) && used && active_q[vidx];

  assign ls_s      = signed'(SW'(ls_store_q[vidx]));
  assign ll_s      = signed'(SW'(ll_store_q[vidx]));
  assign end_s     = signed'(SW'(end_q[vidx]));
  assign pos_cur_s = signed'(SW'(frame_pos_q[vidx]));

  // Position update.
  logic [48:0]          f_sum;
  logic [48:0]          whole;
  logic signed [SW-1:0] whole_s, pos_e;
  assign f_sum   = {17'd0, frac_pos_q[vidx]} + {1'b0, step_store_q[vidx]};
  assign whole   = f_sum >> FRAC_BITS;
  assign whole_s = signed'(SW'(whole));
  assign pos_e   = back_q[vidx] ? (pos_cur_s - whole_s) : (pos_cur_s + whole_s);

  // Classification of the new position.
  logic wrap_back, over_end, ll_ge2;
  logic signed [SW-1:0] dvd;
  assign ll_ge2    = (ll_store_q[vidx] >= 24'd2);
  assign wrap_back = back_q[vidx] && (pos_q < ls_s);
  assign over_end  = !wrap_back && (pos_q >= end_s);
  assign dvd       = wrap_back ? (ls_s - pos_q - SW'(1)) : (pos_q - end_s);

  assign sts_o.need_div = adv && ll_ge2 && (wrap_back || over_end);
  assign sts_o.div_done = (cnt_q == CW'(DW - 1));

  // One remainder bit per cycle.
  logic [24:0] r_sh, r_sub;
  logic [23:0] rem_d;
  assign r_sh  = {rem_q, div_q[DW-1]};
  assign r_sub = r_sh - {1'b0, ll_store_q[vidx]};
  assign rem_d = (r_sh >= {1'b0, ll_store_q[vidx]}) ? r_sub[23:0] : r_sh[23:0];

  // Final advance position.
  logic signed [SW-1:0] rem_s, pos_f, pos_c;
  logic                 back_f, act_f;
  assign rem_s = signed'(SW'(rem_q));
  always_comb begin
    pos_f  = pos_q;
    back_f = back_q[vidx];
    act_f  = 1'b1;
    if (wb_q) begin
      back_f = 1'b0;
      pos_f  = ls_s + rem_s;
    end else if (ovr_q) begin
      priority if (mode_q[vidx][1:0] == LOOP_NONE) begin
        act_f = 1'b0;
      end else if (mode_q[vidx][1:0] == LOOP_FWD) begin
        pos_f = ls_s + rem_s;
      end else begin
        back_f = 1'b1;
        pos_f  = end_s - SW'(1) - rem_s;
      end
    end
    priority if (pos_f < 0) begin
      pos_c = '0;
    end else if (pos_f > POS_MAX) begin
      pos_c = POS_MAX;
    end else begin
      pos_c = pos_f;
    end
  end

  // Trigger decode.
  logic [24:0] le_t, le_h, end_t;
  logic [23:0] len_h, ls_h, ll_h;
  logic [1:0]  type_t;
  logic        trig_ok;
  assign le_t    = {1'b0, lb_q} + {1'b0, lspan_q};
  assign le_h    = w16_q ? (le_t >> 1) : le_t;
  assign len_h   = w16_q ? (len_q >> 1) : len_q;
  assign ls_h    = w16_q ? (lb_q >> 1) : lb_q;
  assign ll_h    = w16_q ? (lspan_q >> 1) : lspan_q;
  assign type_t  = (ll_h == 24'd0) ? LOOP_NONE : lmode_q;
  assign end_t   = (type_t != LOOP_NONE) ? le_h : {1'b0, len_h};
  assign trig_ok = present_q && (len_h != 24'd0) && ({1'b0, start_q} < end_t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cin_q <= CIN_RESET;
    end else if (cfg_we_i) begin
      cin_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q     <= cmd_i;
      voice_q   <= voice_i;
      present_q <= sample_present_i;
      len_q     <= sample_length_i;
      lb_q      <= loop_begin_i;
      lspan_q   <= loop_span_i;
      lmode_q   <= loop_mode_i;
      w16_q     <= is_16bit_i;
      start_q   <= start_offset_i;
      step_q    <= step_i;
    end
    if (ctl_i.eval) begin
      pos_q    <= pos_e;
      frac_n_q <= f_sum[FRAC_BITS-1:0];
    end
    if (ctl_i.classify) begin
      wb_q  <= wrap_back;
      ovr_q <= over_end;
      div_q <= DW'(dvd);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (ctl_i.div_step) begin
      rem_q <= rem_d;
      div_q <= {div_q[DW-2:0], 1'b0};
      cnt_q <= cnt_q + CW'(1);
    end
    if (ctl_i.commit && used && (cmd_q == CMD_TRIGGER) && trig_ok) begin
      ls_store_q[vidx] <= ls_h;
      ll_store_q[vidx] <= ll_h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      back_q   <= '0;
      for (int i = 0; i < VOICES; i++) begin
        frame_pos_q[i]  <= '0;
        frac_pos_q[i]   <= '0;
        step_store_q[i] <= '0;
        end_q[i]        <= '0;
        mode_q[i]       <= '0;
      end
    end else if (ctl_i.commit) begin
      if (cmd_q == CMD_STOP_ALL) begin
        active_q <= '0;
      end else if (used) begin
        unique case (cmd_q)
          CMD_TRIGGER: begin
            active_q[vidx] <= trig_ok;
            if (trig_ok) begin
              mode_q[vidx]      <= {w16_q, type_t};
              end_q[vidx]       <= end_t;
              frame_pos_q[vidx] <= FPW'(start_q);
              frac_pos_q[vidx]  <= '0;
              back_q[vidx]      <= 1'b0;
            end
          end
          CMD_SET_STEP: step_store_q[vidx] <= step_q;
          CMD_ADVANCE: begin
            if (active_q[vidx]) begin
              active_q[vidx]    <= act_f;
              back_q[vidx]      <= back_f;
              frame_pos_q[vidx] <= FPW'(pos_c);
              frac_pos_q[vidx]  <= frac_n_q;
            end
          end
          default: active_q <= active_q;
        endcase
      end
    end
  end

  // Output word.
  logic        o_valid;
  logic [24:0] o_bytes;
  assign o_valid = active_q[vidx] && (end_q[vidx] != 25'd0) && (pos_cur_s < end_s);
  assign o_bytes = mode_q[vidx][2] ? 25'({frame_pos_q[vidx], 1'b0})
                                   : 25'(frame_pos_q[vidx]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      voice_active_o        <= used && active_q[vidx];
      frame_position_o      <= used ? frame_pos_q[vidx][23:0] : 24'd0;
      going_backwards_o     <= used && back_q[vidx];
      byte_position_valid_o <= used && o_valid;
      byte_position_o       <= (used && o_valid) ? o_bytes : 25'd0;
    end
  end

endmodule
